/* rtl/bdlp_pkg.sv */
// Shared types and constants for the button debounce and long-press block.
package bdlp_pkg;

    localparam int NUM_INPUT_BITS = 5;  // raw input bits and held mask bits
    localparam int FUNC_W         = 3;
    localparam int INDEX_W        = 3;
    localparam int TIME_W         = 32;
    localparam int DEB_W          = 8;
    localparam int LONG_W         = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int IN_DATA_W      = 48;
    localparam int OUT_DATA_W     = 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_POLL     = 3'd0,
        FN_PRESSED  = 3'd1,
        FN_RELEASED = 3'd2,
        FN_LONG     = 3'd3,
        FN_HELD     = 3'd4
    } t_func;

    typedef enum logic {
        CFG_DEBOUNCE_TIME   = 1'b0,
        CFG_LONG_PRESS_TIME = 1'b1
    } t_cfg_index;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET   = 8'd5;
    localparam logic [LONG_W-1:0] LONG_PRESS_RESET = 16'd600;

    // Per-request control shared by every lane.
    typedef struct packed {
        logic               accept;
        t_func              func;
        logic [INDEX_W-1:0] button_index;
        logic [TIME_W-1:0]  now_ms;
        logic [DEB_W-1:0]   debounce_time;
        logic [LONG_W-1:0]  long_press_time;
    } t_lane_ctl;

    // What one lane reports to the merge stage.
    typedef struct packed {
        logic flag;
        logic stable_next;
    } t_lane_res;

endpackage

/* rtl/bdlp_lane.sv */
// One button lane: debounce, edge events and long-press detection.
module bdlp_lane
    import bdlp_pkg::*;
#(
    parameter int LANE = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_ctl i_ctl,
    input  logic      i_raw,
    output t_lane_res o_res
);

    logic              r_last_raw, r_stable, r_pressed_ev, r_released_ev;
    logic              r_long_ev, r_long_done;
    logic [TIME_W-1:0] r_change_time, r_press_start;

    logic              raw_chg, stab_chg, stab_press, long_hit, sel, ld_eff;
    logic [TIME_W-1:0] deb_elapsed, long_elapsed;
    logic              stable_eff;

    assign raw_chg     = i_raw != r_last_raw;
    // A fresh raw change has zero elapsed time.
    assign deb_elapsed = raw_chg ? '0 : (i_ctl.now_ms - r_change_time);
    assign stab_chg    = (deb_elapsed >= {{(TIME_W-DEB_W){1'b0}}, i_ctl.debounce_time})
                         && (i_raw != r_stable);
    assign stab_press  = stab_chg && i_raw;
    assign stable_eff  = stab_chg ? i_raw : r_stable;
    assign ld_eff      = stab_press ? 1'b0 : r_long_done;
    assign long_elapsed = stab_press ? '0 : (i_ctl.now_ms - r_press_start);
    assign long_hit    = stable_eff && !ld_eff
                         && (long_elapsed >= {{(TIME_W-LONG_W){1'b0}}, i_ctl.long_press_time});

    assign sel = (int'(i_ctl.button_index) == LANE);

    always_comb begin
        o_res.flag        = 1'b0;
        o_res.stable_next = r_stable;
        case (i_ctl.func)
            FN_POLL: begin
                o_res.stable_next = stable_eff;
            end
            FN_PRESSED:  o_res.flag = sel && r_pressed_ev;
            FN_RELEASED: o_res.flag = sel && r_released_ev;
            FN_LONG:     o_res.flag = sel && r_long_ev;
            FN_HELD:     o_res.flag = sel && r_stable;
            default:     o_res.flag = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= 1'b0;
            r_stable      <= 1'b0;
            r_pressed_ev  <= 1'b0;
            r_released_ev <= 1'b0;
            r_long_ev     <= 1'b0;
            r_long_done   <= 1'b0;
            r_change_time <= '0;
            r_press_start <= '0;
        end else if (i_ctl.accept) begin
            case (i_ctl.func)
                FN_POLL: begin
                    r_last_raw <= i_raw;
                    if (raw_chg) begin
                        r_change_time <= i_ctl.now_ms;
                    end
                    r_stable <= stable_eff;
                    if (stab_press) begin
                        r_pressed_ev  <= 1'b1;
                        r_press_start <= i_ctl.now_ms;
                    end
                    if (stab_chg && !i_raw) begin
                        r_released_ev <= 1'b1;
                    end
                    r_long_done <= ld_eff || long_hit;
                    if (long_hit) begin
                        r_long_ev <= 1'b1;
                    end
                end
                FN_PRESSED: begin
                    if (sel) r_pressed_ev <= 1'b0;
                end
                FN_RELEASED: begin
                    if (sel) r_released_ev <= 1'b0;
                end
                FN_LONG: begin
                    if (sel) r_long_ev <= 1'b0;
                end
                default: ;
            endcase
        end
    end

endmodule

/* rtl/bdlp_merge.sv */
// Merge stage: combine lane flags and build the held mask.
module bdlp_merge
    import bdlp_pkg::*;
#(
    parameter int NUM_BUTTONS = 5
) (
    input  t_lane_res                  i_res [NUM_BUTTONS],
    output logic                       o_flag,
    output logic [NUM_INPUT_BITS-1:0]  o_held_mask
);

    // At most one lane is selected, so an OR picks its flag.
    always_comb begin
        o_flag      = 1'b0;
        o_held_mask = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            o_flag = o_flag | i_res[i].flag;
            if (i < NUM_INPUT_BITS) begin
                o_held_mask[i] = i_res[i].stable_next;
            end
        end
    end

endmodule

/* rtl/button_debounce_long_press.sv */
// Top level of the button debounce and long-press qualifier bank.
//
// Usage:
//   Slave stream (i_s_*) carries one request per beat: a poll with a raw
//   pressed bit per button and a millisecond timestamp, or a read of one
//   button's pressed, released or long event (read and clear) or its held
//   level. Master stream (o_m_*) returns one result per request: the
//   requested flag and the debounced held mask after the request.
//   Configuration writes (debounce time, long-press time) go through the
//   plain write port while the block is idle; the user must keep to this, as the block does not enforce it.
// Throughput:
//   One request per cycle while o_s_tready is high. Every button lane
//   updates in parallel with subtract-and-compare logic, and the result is
//   registered in the output register, or in the skid register if it is full.
// Reset (synchronous, active low):
//   All buttons start released with no events; debounce time 5 ms,
//   long-press time 600 ms; both output stages empty.
// Stall:
//   A skid register behind the output register takes one more request while
//   the receiver stalls; tready drops only when both stages hold results.
module button_debounce_long_press
    import bdlp_pkg::*;
#(
    parameter int NUM_BUTTONS = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave request stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata: func[2:0], raw_pressed[7:3], now_ms[39:8], button_index[42:40], zero pad
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // Master result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata: flag[0], held_mask[5:1], zero pad
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // Configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [DEB_W-1:0]      r_debounce_time;
    logic [LONG_W-1:0]     r_long_press_time;
    logic                  r_out_valid, r_skid_valid;
    logic [OUT_DATA_W-1:0] r_out_data, r_skid_data;

    t_lane_ctl                   lane_ctl;
    t_lane_res                   lane_res [NUM_BUTTONS];
    logic                        accept, take, res_flag;
    logic [NUM_INPUT_BITS-1:0]   raw_bits, held_mask;
    logic [OUT_DATA_W-1:0]       res_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time   <= DEBOUNCE_RESET;
            r_long_press_time <= LONG_PRESS_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_addr))
                CFG_DEBOUNCE_TIME:   r_debounce_time   <= i_cfg_data[DEB_W-1:0];
                CFG_LONG_PRESS_TIME: r_long_press_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Accept while the skid stage is free.
    assign o_s_tready = !r_skid_valid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign take       = r_out_valid && i_m_tready;

    assign raw_bits = i_s_tdata[7:3];

    always_comb begin
        lane_ctl.accept          = accept;
        lane_ctl.func            = t_func'(i_s_tdata[2:0]);
        lane_ctl.now_ms          = i_s_tdata[39:8];
        lane_ctl.button_index    = i_s_tdata[42:40];
        lane_ctl.debounce_time   = r_debounce_time;
        lane_ctl.long_press_time = r_long_press_time;
    end

    // One lane per button; buttons beyond the input bits see released.
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        logic lane_raw;
        if (g < NUM_INPUT_BITS) begin : g_bit
            assign lane_raw = raw_bits[g];
        end else begin : g_nobit
            assign lane_raw = 1'b0;
        end
        bdlp_lane #(
            .LANE (g)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_raw   (lane_raw),
            .o_res   (lane_res[g])
        );
    end

    bdlp_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_res       (lane_res),
        .o_flag      (res_flag),
        .o_held_mask (held_mask)
    );

    assign res_data = {2'b00, held_mask, res_flag};

    // Output register with a skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (accept) begin
                r_out_data <= res_data;
            end
        end else if (accept) begin
            r_skid_data <= res_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
